@@ src/ttf_pkg.sv @@
// ttf_pkg: shared beat types and constants for the triangle tangent frame block
`timescale 1ns / 1ps
package ttf_pkg;

   localparam int POS_W   = 48;
   localparam int UV_W    = 32;
   localparam int VEC_W   = 48;

   // normaliser constants
   localparam int SCALE_TOP    = 29;
   localparam int MAG_W        = 30;
   localparam int SQ_W         = 60;
   localparam int SUM_W        = 62;
   localparam int ROOT_W       = 31;
   localparam int ROOT_STEPS   = 31;
   localparam int ISQ_STAGES   = 16;
   localparam int SETUP_STAGES = 4;

   typedef struct packed {
      logic [POS_W-1:0] pos_first;
      logic [POS_W-1:0] pos_second;
      logic [POS_W-1:0] pos_third;
      logic [UV_W-1:0]  uv_first;
      logic [UV_W-1:0]  uv_second;
      logic [UV_W-1:0]  uv_third;
      logic [VEC_W-1:0] nrm_first;
      logic [VEC_W-1:0] nrm_second;
      logic [VEC_W-1:0] nrm_third;
   } req_type;

   typedef struct packed {
      logic [VEC_W-1:0] out_nrm_first;
      logic [VEC_W-1:0] out_nrm_second;
      logic [VEC_W-1:0] out_nrm_third;
      logic [VEC_W-1:0] tangent_dir;
      logic [VEC_W-1:0] bitangent_dir;
      logic             frame_valid;
   } rsp_type;

   // stage count of one normaliser
   function automatic int norm_stages(input int cb);
      return 23 + (cb >> 1);
   endfunction

endpackage

@@ src/ttf_isqrt.sv @@
// ttf_isqrt: pipelined integer square root, two result bits per stage
`timescale 1ns / 1ps
module ttf_isqrt
   import ttf_pkg::*;
(
   input  logic                  clock,
   input  logic [ISQ_STAGES-1:0] en_i,
   input  logic [SUM_W-1:0]      s_i,
   output logic [ROOT_W-1:0]     r_o
);

   logic [SUM_W-1:0] s_ff   [ISQ_STAGES];
   logic [SUM_W-1:0] res_ff [ISQ_STAGES];
   logic [SUM_W-1:0] s_in   [ISQ_STAGES];
   logic [SUM_W-1:0] res_in [ISQ_STAGES];

   always_comb begin
      logic [SUM_W-1:0] sv;
      logic [SUM_W-1:0] rv;
      logic [SUM_W-1:0] bv;
      int               j;
      for (int k = 0; k < ISQ_STAGES; k++) begin
         sv = (k == 0) ? s_i : s_ff[k-1];
         rv = (k == 0) ? '0 : res_ff[k-1];
         for (int st = 0; st < 2; st++) begin
            j = 2 * k + st;
            if (j < ROOT_STEPS) begin
               bv = SUM_W'(1) << (2 * (ROOT_STEPS - 1 - j));
               if (sv >= rv + bv) begin
                  sv = sv - (rv + bv);
                  rv = (rv >> 1) + bv;
               end else begin
                  rv = rv >> 1;
               end
            end
         end
         s_in[k]   = sv;
         res_in[k] = rv;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ISQ_STAGES; k++) begin
         if (en_i[k]) begin
            s_ff[k]   <= s_in[k];
            res_ff[k] <= res_in[k];
         end
      end
   end

   assign r_o = res_ff[ISQ_STAGES-1][ROOT_W-1:0];

endmodule

@@ src/ttf_norm.sv @@
// ttf_norm: pipelined vector normaliser to Q1.F unit components
`timescale 1ns / 1ps
module ttf_norm
   import ttf_pkg::*;
#(
   parameter  int CB = 16,
   localparam int VW = 2 * CB + 3,
   localparam int NL = norm_stages(CB)
)
(
   input  logic                 clock,
   input  logic [NL-1:0]        en_i,
   input  logic signed [VW-1:0] vec_i [3],
   output logic [VEC_W-1:0]     vec_o
);

   localparam int F      = CB - 2;
   localparam int DS     = CB / 2;
   localparam int DW     = 32 + F;
   localparam int LW     = $clog2(VW);
   localparam int ST_ISQ = 5;
   localparam int ST_LM  = ST_ISQ + ISQ_STAGES - 1;
   localparam int ST_NX  = ST_LM + 1;
   localparam int ST_OUT = ST_NX + DS + 1;

   logic [VW-1:0]     mag0_ff [3];
   logic [VW-1:0]     mag1_ff [3];
   logic [LW-1:0]     p_ff;
   logic              neg_d  [0:ST_OUT-1][3];
   logic              zero_d [1:ST_OUT-1];
   logic [MAG_W-1:0]  m_d    [2:ST_LM][3];
   logic [SQ_W-1:0]   sq_ff  [3];
   logic [SUM_W-1:0]  sum_ff;
   logic [ROOT_W-1:0] root;
   logic [ROOT_W-1:0] r_d    [0:DS];
   logic [DW-1:0]     rem_ff [0:DS][3];
   logic [F:0]        q_ff   [0:DS][3];
   logic [DW-1:0]     rem_in [1:DS][3];
   logic [F:0]        q_in   [1:DS][3];
   logic [VW-1:0]     orv;
   logic [LW-1:0]     p_in;
   logic [VW+28:0]    wide   [3];
   logic [CB-1:0]     comp   [3];
   logic [VEC_W-1:0]  vec_ff;

   // leading one of the or of all magnitudes is that of the largest
   always_comb begin
      orv  = mag0_ff[0] | mag0_ff[1] | mag0_ff[2];
      p_in = '0;
      for (int b = 0; b < VW; b++) begin
         if (orv[b]) p_in = LW'(b);
      end
      for (int c = 0; c < 3; c++) wide[c] = {mag1_ff[c], {SCALE_TOP{1'b0}}} >> p_ff;
   end

   ttf_isqrt u_isqrt (
      .clock (clock),
      .en_i  (en_i[ST_LM:ST_ISQ]),
      .s_i   (sum_ff),
      .r_o   (root)
   );

   // restoring division, two quotient bits per stage
   always_comb begin
      logic [DW-1:0] rv;
      logic [DW-1:0] dv;
      logic [F:0]    qv;
      int            t;
      for (int d = 1; d <= DS; d++) begin
         for (int c = 0; c < 3; c++) begin
            rv = rem_ff[d-1][c];
            qv = q_ff[d-1][c];
            for (int st = 0; st < 2; st++) begin
               t = 2 * (d - 1) + st;
               if (t <= F) begin
                  dv = DW'(r_d[d-1]) << (F - t);
                  if (rv >= dv) begin
                     rv        = rv - dv;
                     qv[F - t] = 1'b1;
                  end
               end
            end
            rem_in[d][c] = rv;
            q_in[d][c]   = qv;
         end
      end
   end

   always_comb begin
      logic [F:0] qc;
      for (int c = 0; c < 3; c++) begin
         qc = q_ff[DS][c];
         if (qc > (F+1)'(1) << F) qc = (F+1)'(1) << F;
         if (zero_d[ST_OUT-1])              comp[c] = '0;
         else if (neg_d[ST_OUT-1][c])       comp[c] = CB'(0) - CB'(qc);
         else                               comp[c] = CB'(qc);
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (en_i[0]) begin
            neg_d[0][c] <= vec_i[c][VW-1];
            mag0_ff[c]  <= vec_i[c][VW-1] ? VW'(0) - VW'(vec_i[c]) : VW'(vec_i[c]);
         end
         if (en_i[1]) mag1_ff[c] <= mag0_ff[c];
         if (en_i[2]) m_d[2][c] <= wide[c][MAG_W-1:0];
         if (en_i[3]) sq_ff[c] <= SQ_W'(m_d[2][c]) * SQ_W'(m_d[2][c]);
         for (int k = 1; k < ST_OUT; k++) begin
            if (en_i[k]) neg_d[k][c] <= neg_d[k-1][c];
         end
         for (int k = 3; k <= ST_LM; k++) begin
            if (en_i[k]) m_d[k][c] <= m_d[k-1][c];
         end
         if (en_i[ST_NX]) begin
            rem_ff[0][c] <= (DW'(m_d[ST_LM][c]) << F) + DW'(root >> 1);
            q_ff[0][c]   <= '0;
         end
         for (int d = 1; d <= DS; d++) begin
            if (en_i[ST_NX + d]) begin
               rem_ff[d][c] <= rem_in[d][c];
               q_ff[d][c]   <= q_in[d][c];
            end
         end
      end
      if (en_i[1]) begin
         p_ff      <= p_in;
         zero_d[1] <= (orv == '0);
      end
      for (int k = 2; k < ST_OUT; k++) begin
         if (en_i[k]) zero_d[k] <= zero_d[k-1];
      end
      if (en_i[4]) sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      if (en_i[ST_NX]) r_d[0] <= root;
      for (int d = 1; d <= DS; d++) begin
         if (en_i[ST_NX + d]) r_d[d] <= r_d[d-1];
      end
      if (en_i[ST_OUT]) vec_ff <= VEC_W'({comp[0], comp[1], comp[2]});
   end

   assign vec_o = vec_ff;

endmodule

@@ src/ttf_setup.sv @@
// ttf_setup: edge vectors, products, face normal, uv determinant and tangent terms
`timescale 1ns / 1ps
module ttf_setup
   import ttf_pkg::*;
#(
   parameter  int CB = 16,
   localparam int VW = 2 * CB + 3
)
(
   input  logic                    clock,
   input  logic [SETUP_STAGES-1:0] en_i,
   input  req_type                 req_i,
   output logic signed [VW-1:0]    nv_o [3],
   output logic signed [VW-1:0]    tv_o [3],
   output logic signed [VW-1:0]    bv_o [3],
   output logic                    fv_o
);

   localparam int PW = 2 * CB + 2;

   logic [3*CB-1:0]        pw [3];
   logic [2*CB-1:0]        tw [3];
   logic signed [CB-1:0]   pc [3][3];
   logic signed [CB-1:0]   tc [3][2];
   logic signed [CB:0]     e1_in [3], e2_in [3];
   logic signed [CB:0]     e1_ff [3], e2_ff [3];
   logic signed [CB:0]     du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [PW-1:0]   cr_ff [6];
   logic signed [PW-1:0]   dp_ff [2];
   logic signed [PW-1:0]   ta_ff [3], tb_ff [3], ba_ff [3], bb_ff [3];
   logic signed [VW-1:0]   nv_ff [3], tv_ff [3], bv_ff [3];
   logic signed [VW-1:0]   det;
   logic                   dneg_ff, fv3_ff;
   logic signed [VW-1:0]   nvo_ff [3], tvo_ff [3], bvo_ff [3];
   logic                   fvo_ff;

   always_comb begin
      pw[0] = (3*CB)'(req_i.pos_first);
      pw[1] = (3*CB)'(req_i.pos_second);
      pw[2] = (3*CB)'(req_i.pos_third);
      tw[0] = (2*CB)'(req_i.uv_first);
      tw[1] = (2*CB)'(req_i.uv_second);
      tw[2] = (2*CB)'(req_i.uv_third);
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) pc[k][i] = pw[k][(2-i)*CB +: CB];
         for (int i = 0; i < 2; i++) tc[k][i] = tw[k][(1-i)*CB +: CB];
      end
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = (CB+1)'(pc[1][i]) - (CB+1)'(pc[0][i]);
         e2_in[i] = (CB+1)'(pc[2][i]) - (CB+1)'(pc[0][i]);
      end
      det = VW'(dp_ff[0]) - VW'(dp_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (en_i[0]) begin
         e1_ff  <= e1_in;
         e2_ff  <= e2_in;
         du1_ff <= (CB+1)'(tc[1][0]) - (CB+1)'(tc[0][0]);
         dv1_ff <= (CB+1)'(tc[1][1]) - (CB+1)'(tc[0][1]);
         du2_ff <= (CB+1)'(tc[2][0]) - (CB+1)'(tc[0][0]);
         dv2_ff <= (CB+1)'(tc[2][1]) - (CB+1)'(tc[0][1]);
      end
      if (en_i[1]) begin
         cr_ff[0] <= PW'(e1_ff[1]) * PW'(e2_ff[2]);
         cr_ff[1] <= PW'(e1_ff[2]) * PW'(e2_ff[1]);
         cr_ff[2] <= PW'(e1_ff[2]) * PW'(e2_ff[0]);
         cr_ff[3] <= PW'(e1_ff[0]) * PW'(e2_ff[2]);
         cr_ff[4] <= PW'(e1_ff[0]) * PW'(e2_ff[1]);
         cr_ff[5] <= PW'(e1_ff[1]) * PW'(e2_ff[0]);
         dp_ff[0] <= PW'(du1_ff) * PW'(dv2_ff);
         dp_ff[1] <= PW'(du2_ff) * PW'(dv1_ff);
         for (int i = 0; i < 3; i++) begin
            ta_ff[i] <= PW'(dv2_ff) * PW'(e1_ff[i]);
            tb_ff[i] <= PW'(dv1_ff) * PW'(e2_ff[i]);
            ba_ff[i] <= PW'(du1_ff) * PW'(e2_ff[i]);
            bb_ff[i] <= PW'(du2_ff) * PW'(e1_ff[i]);
         end
      end
      if (en_i[2]) begin
         for (int i = 0; i < 3; i++) begin
            nv_ff[i] <= VW'(cr_ff[2*i]) - VW'(cr_ff[2*i+1]);
            tv_ff[i] <= VW'(ta_ff[i]) - VW'(tb_ff[i]);
            bv_ff[i] <= VW'(ba_ff[i]) - VW'(bb_ff[i]);
         end
         dneg_ff <= det[VW-1];
         fv3_ff  <= (det != '0);
      end
      if (en_i[3]) begin
         // a negative determinant flips both directions
         for (int i = 0; i < 3; i++) begin
            nvo_ff[i] <= nv_ff[i];
            tvo_ff[i] <= dneg_ff ? VW'(0) - tv_ff[i] : tv_ff[i];
            bvo_ff[i] <= dneg_ff ? VW'(0) - bv_ff[i] : bv_ff[i];
         end
         fvo_ff <= fv3_ff;
      end
   end

   assign nv_o = nvo_ff;
   assign tv_o = tvo_ff;
   assign bv_o = bvo_ff;
   assign fv_o = fvo_ff;

endmodule

@@ src/triangle_tangent_frame_top.sv @@
// triangle_tangent_frame_top: per-triangle face normal, tangent and bitangent
`timescale 1ns / 1ps
// throughput: one triangle per cycle unless rsp_ready holds the output; every
//   stage advances when it is empty or its successor advances, so the pipe keeps
//   filling while a rsp beat waits
// depth is set by the pipelined square root (16 stages) and the restoring divider
// reset: synchronous, clears all valid bits and renormalize_mode
module triangle_tangent_frame_top
   import ttf_pkg::*;
#(
   parameter int COMPONENT_BITS = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic    csr_wdata
);

   localparam int CB  = COMPONENT_BITS;
   localparam int VW  = 2 * CB + 3;
   localparam int NL  = norm_stages(CB);
   localparam int LAT = SETUP_STAGES + NL;

   // per-stage valid bits and advance enables
   logic [LAT-1:0]     vld_ff;
   logic [LAT-1:0]     vld_in;
   logic [LAT:0]       en;
   logic               rsp_vld_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic               mode_ff;

   logic signed [VW-1:0] nv [3];
   logic signed [VW-1:0] tv [3];
   logic signed [VW-1:0] bv [3];
   logic                 fv;
   logic [VEC_W-1:0]     face_dir, tan_dir, bit_dir;

   // pass-through normals and frame flag, carried alongside the maths
   logic [3*VEC_W-1:0]   nrm_d [LAT];
   logic                 fv_d  [SETUP_STAGES:LAT-1];

   always_comb begin
      en[LAT] = !rsp_vld_ff || rsp_ready;
      for (int k = LAT - 1; k >= 0; k--) en[k] = !vld_ff[k] || en[k+1];
      for (int k = 0; k < LAT; k++) begin
         if (!en[k])      vld_in[k] = vld_ff[k];
         else if (k == 0) vld_in[k] = req_valid;
         else             vld_in[k] = vld_ff[k-1];
      end
   end

   assign req_ready = en[0];

   ttf_setup #(.CB(CB)) u_setup (
      .clock (clock),
      .en_i  (en[SETUP_STAGES-1:0]),
      .req_i (req_data),
      .nv_o  (nv),
      .tv_o  (tv),
      .bv_o  (bv),
      .fv_o  (fv)
   );

   ttf_norm #(.CB(CB)) u_norm_face (
      .clock (clock),
      .en_i  (en[LAT-1:SETUP_STAGES]),
      .vec_i (nv),
      .vec_o (face_dir)
   );

   ttf_norm #(.CB(CB)) u_norm_tan (
      .clock (clock),
      .en_i  (en[LAT-1:SETUP_STAGES]),
      .vec_i (tv),
      .vec_o (tan_dir)
   );

   ttf_norm #(.CB(CB)) u_norm_bit (
      .clock (clock),
      .en_i  (en[LAT-1:SETUP_STAGES]),
      .vec_i (bv),
      .vec_o (bit_dir)
   );

   // result assembly reads mode; the user keeps mode changes to idle, unchecked
   always_comb begin
      if (mode_ff) begin
         rsp_in.out_nrm_first  = face_dir;
         rsp_in.out_nrm_second = face_dir;
         rsp_in.out_nrm_third  = face_dir;
      end else begin
         rsp_in.out_nrm_first  = nrm_d[LAT-1][3*VEC_W-1:2*VEC_W];
         rsp_in.out_nrm_second = nrm_d[LAT-1][2*VEC_W-1:VEC_W];
         rsp_in.out_nrm_third  = nrm_d[LAT-1][VEC_W-1:0];
      end
      rsp_in.frame_valid   = fv_d[LAT-1];
      rsp_in.tangent_dir   = fv_d[LAT-1] ? tan_dir : '0;
      rsp_in.bitangent_dir = fv_d[LAT-1] ? bit_dir : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
         mode_ff    <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (en[LAT]) rsp_vld_ff <= vld_ff[LAT-1];
         if (csr_we)  mode_ff    <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) nrm_d[0] <= {req_data.nrm_first, req_data.nrm_second, req_data.nrm_third};
      for (int k = 1; k < LAT; k++) begin
         if (en[k]) nrm_d[k] <= nrm_d[k-1];
      end
      if (en[SETUP_STAGES]) fv_d[SETUP_STAGES] <= fv;
      for (int k = SETUP_STAGES + 1; k < LAT; k++) begin
         if (en[k]) fv_d[k] <= fv_d[k-1];
      end
      if (en[LAT]) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ test/triangle_tangent_frame_top_tb.sv @@
// triangle_tangent_frame_top_tb: checks face normals, tangents and bitangents against a predictor
`timescale 1ns / 1ps
module triangle_tangent_frame_top_tb;
   import ttf_pkg::*;

   localparam int CB       = 16;
   localparam int FB       = CB - 2;
   localparam int LATENCY  = 28 + CB / 2;
   localparam int CYCLE_LIMIT = 400000;

   // idling phases
   typedef enum int {PH_NONE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_we;
   logic    csr_wdata;

   triangle_tangent_frame_top #(.COMPONENT_BITS(CB)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   rsp_type frames_due[$];
   int      mismatches = 0;
   int      cycles = 0;
   logic    renorm_mode = 1'b0;
   int      recv_stall_pct = 0;
   int      hold_off = 0;

   // signed component of a packed vector, idx 0 is the high one
   function automatic longint comp_of(logic [47:0] packed_v, int cnt, int idx);
      logic [CB-1:0] raw;
      raw = CB'(packed_v >> ((cnt - 1 - idx) * CB));
      return longint'(signed'(raw));
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] s);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else res >>= 1;
         bitv >>= 2;
      end
      return res;
   endfunction

   // unit vector, q1.f packed, zero stays zero
   function automatic logic [47:0] unit_vec(longint vx, longint vy, longint vz);
      logic [63:0] mag[3];
      logic [63:0] top, sum, root, q;
      logic        neg[3];
      longint      c[3];
      longint      v[3];
      logic [47:0] packed_v;
      v[0] = vx; v[1] = vy; v[2] = vz;
      top = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
         if (mag[i] > top) top = mag[i];
      end
      if (top == 0) return '0;
      while (top >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
         top >>= 1;
      end
      while (top < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
         top <<= 1;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
      root = root_floor(sum);
      packed_v = '0;
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << FB) + (root >> 1)) / root;
         if (q > (64'd1 << FB)) q = 64'd1 << FB;
         c[i] = neg[i] ? -longint'(q) : longint'(q);
         packed_v |= 48'(c[i] & ((64'd1 << CB) - 1)) << ((2 - i) * CB);
      end
      return packed_v;
   endfunction

   function automatic rsp_type predict_frame(req_type t, logic renorm);
      longint p[3][3], uv[3][2], e1[3], e2[3], tv[3], bv[3];
      longint du1, dv1, du2, dv2, det;
      logic [47:0] pos[3];
      logic [47:0] tex[3];
      logic [47:0] face;
      rsp_type r;
      pos[0] = t.pos_first; pos[1] = t.pos_second; pos[2] = t.pos_third;
      tex[0] = 48'(t.uv_first);  tex[1] = 48'(t.uv_second);  tex[2] = 48'(t.uv_third);
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) p[k][i] = comp_of(pos[k], 3, i);
         for (int i = 0; i < 2; i++) uv[k][i] = comp_of(tex[k], 2, i);
      end
      for (int i = 0; i < 3; i++) begin
         e1[i] = p[1][i] - p[0][i];
         e2[i] = p[2][i] - p[0][i];
      end
      if (renorm) begin
         face = unit_vec(e1[1] * e2[2] - e1[2] * e2[1], e1[2] * e2[0] - e1[0] * e2[2],
                         e1[0] * e2[1] - e1[1] * e2[0]);
         r.out_nrm_first = face; r.out_nrm_second = face; r.out_nrm_third = face;
      end else begin
         r.out_nrm_first = t.nrm_first;
         r.out_nrm_second = t.nrm_second;
         r.out_nrm_third = t.nrm_third;
      end
      du1 = uv[1][0] - uv[0][0];
      dv1 = uv[1][1] - uv[0][1];
      du2 = uv[2][0] - uv[0][0];
      dv2 = uv[2][1] - uv[0][1];
      det = du1 * dv2 - du2 * dv1;
      if (det != 0) begin
         for (int i = 0; i < 3; i++) begin
            tv[i] = dv2 * e1[i] - dv1 * e2[i];
            bv[i] = du1 * e2[i] - du2 * e1[i];
            if (det < 0) begin
               tv[i] = -tv[i];
               bv[i] = -bv[i];
            end
         end
         r.tangent_dir = unit_vec(tv[0], tv[1], tv[2]);
         r.bitangent_dir = unit_vec(bv[0], bv[1], bv[2]);
         r.frame_valid = 1'b1;
      end else begin
         r.tangent_dir = '0;
         r.bitangent_dir = '0;
         r.frame_valid = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [47:0] pack_pos(int x, int y, int z);
      return {16'(x), 16'(y), 16'(z)};
   endfunction

   // random component, often small so that edges stay well shaped
   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         default: return 16'(int'($urandom_range(0, 1024)) - 512);
      endcase
   endfunction

   function automatic req_type random_triangle();
      req_type t;
      t.pos_first  = {rand_comp(), rand_comp(), rand_comp()};
      t.pos_second = {rand_comp(), rand_comp(), rand_comp()};
      t.pos_third  = {rand_comp(), rand_comp(), rand_comp()};
      t.uv_first   = {rand_comp(), rand_comp()};
      t.uv_second  = {rand_comp(), rand_comp()};
      t.uv_third   = {rand_comp(), rand_comp()};
      // sometimes collapse the uv set to hit the zero determinant case
      if ($urandom_range(0, 9) == 0) t.uv_third = t.uv_second;
      if ($urandom_range(0, 19) == 0) t.pos_third = t.pos_second;
      t.nrm_first  = 48'({$urandom, $urandom});
      t.nrm_second = 48'({$urandom, $urandom});
      t.nrm_third  = 48'({$urandom, $urandom});
      return t;
   endfunction

   // directed stimulus table; expected frame typed in where obvious
   typedef struct {
      req_type tri_in;
      logic    has_known;
      rsp_type known;
   } directed_row_type;

   directed_row_type directed_rows[$];

   function automatic req_type make_tri(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                                        logic [31:0] ua, logic [31:0] ub, logic [31:0] uc,
                                        logic [47:0] n);
      req_type t;
      t.pos_first = a; t.pos_second = b; t.pos_third = c;
      t.uv_first = ua; t.uv_second = ub; t.uv_third = uc;
      t.nrm_first = n; t.nrm_second = ~n; t.nrm_third = {n[23:0], n[47:24]};
      return t;
   endfunction

   task automatic build_table();
      directed_row_type row;
      rsp_type z;
      z = '0;
      // all zero: zero determinant, normals pass through
      row.tri_in = '0; row.has_known = 1'b1; row.known = z;
      directed_rows.insert(directed_rows.size(), row);
      // right triangle in xy with legs of 256 and uv aligned: tangent +x, bitangent +y
      row.tri_in = make_tri(pack_pos(0, 0, 0), pack_pos(256, 0, 0), pack_pos(0, 256, 0),
                            {16'd0, 16'd0}, {16'd4096, 16'd0}, {16'd0, 16'd4096},
                            48'h0000_0000_4000);
      row.has_known = 1'b1;
      row.known.out_nrm_first = row.tri_in.nrm_first;
      row.known.out_nrm_second = row.tri_in.nrm_second;
      row.known.out_nrm_third = row.tri_in.nrm_third;
      row.known.tangent_dir = pack_pos(16384, 0, 0);
      row.known.bitangent_dir = pack_pos(0, 16384, 0);
      row.known.frame_valid = 1'b1;
      directed_rows.insert(directed_rows.size(), row);
      // flipped uv: negative determinant
      row.tri_in = make_tri(pack_pos(0, 0, 0), pack_pos(256, 0, 0), pack_pos(0, 256, 0),
                            {16'd0, 16'd0}, {16'd0, 16'd4096}, {16'd4096, 16'd0},
                            48'hffff_ffff_ffff);
      row.has_known = 1'b0;
      directed_rows.insert(directed_rows.size(), row);
      // degenerate positions with nonzero determinant
      row.tri_in = make_tri(pack_pos(5, 5, 5), pack_pos(5, 5, 5), pack_pos(5, 5, 5),
                            {16'd0, 16'd0}, {16'd4096, 16'd0}, {16'd0, 16'd4096},
                            48'h8000_8000_8000);
      row.has_known = 1'b1;
      row.known.out_nrm_first = row.tri_in.nrm_first;
      row.known.out_nrm_second = row.tri_in.nrm_second;
      row.known.out_nrm_third = row.tri_in.nrm_third;
      row.known.tangent_dir = '0;
      row.known.bitangent_dir = '0;
      row.known.frame_valid = 1'b1;
      directed_rows.insert(directed_rows.size(), row);
      // extremes of every component, all ones, and a small triangle on the unit axes
      row.has_known = 1'b0;
      row.tri_in = make_tri(pack_pos(32767, -32768, 32767), pack_pos(-32768, 32767, -32768),
                            pack_pos(32767, 32767, -32768),
                            {16'h7fff, 16'h8000}, {16'h8000, 16'h7fff}, {16'h7fff, 16'h7fff},
                            48'h7fff_8000_0001);
      directed_rows.insert(directed_rows.size(), row);
      row.tri_in = make_tri(pack_pos(-32768, -32768, -32768), pack_pos(32767, 32767, 32767),
                            pack_pos(-32768, 32767, 0),
                            {16'h8000, 16'h8000}, {16'h7fff, 16'h8000}, {16'h8000, 16'h7fff},
                            48'h0);
      directed_rows.insert(directed_rows.size(), row);
      row.tri_in = '1;
      directed_rows.insert(directed_rows.size(), row);
      row.tri_in = make_tri(pack_pos(1, 0, 0), pack_pos(0, 1, 0), pack_pos(0, 0, 1),
                            {16'd1, 16'd0}, {16'd0, 16'd1}, {16'hffff, 16'hffff},
                            48'h5555_aaaa_5555);
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // sender idle percentage for the current phase
   int send_idle_pct = 0;

   task automatic set_phase(phase_type ph);
      send_idle_pct  = (ph == PH_SEND_IDLE) ? 86 : (ph == PH_BOTH) ? 26 : 0;
      recv_stall_pct = (ph == PH_RECV_STALL) ? 86 : (ph == PH_BOTH) ? 26 : 0;
   endtask

   // one beat: drive, wait for the handshake, record the expectation
   task automatic send_triangle(req_type t, logic has_known, rsp_type known);
      while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      frames_due.insert(frames_due.size(), has_known ? known : predict_frame(t, renorm_mode));
   endtask

   task automatic drain_frames();
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_mode(logic m);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we    <= 1'b0;
      renorm_mode = m;
   endtask

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else
         rsp_ready <= ($urandom_range(1, 100) > recv_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frames_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp beat %h", rsp_data);
         end else begin
            want = frames_due.pop_front();
            if (rsp_data.out_nrm_first !== want.out_nrm_first
                || rsp_data.out_nrm_second !== want.out_nrm_second
                || rsp_data.out_nrm_third !== want.out_nrm_third
                || rsp_data.tangent_dir !== want.tangent_dir
                || rsp_data.bitangent_dir !== want.bitangent_dir
                || rsp_data.frame_valid !== want.frame_valid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("frame mismatch: expected %h actual %h", want, rsp_data);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      rsp_type none;
      none = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      build_table();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at reset mode, then with renormalisation
      foreach (directed_rows[i])
         send_triangle(directed_rows[i].tri_in, directed_rows[i].has_known,
                       directed_rows[i].known);
      drain_frames();
      write_mode(1'b1);
      foreach (directed_rows[i]) send_triangle(directed_rows[i].tri_in, 1'b0, none);
      drain_frames();

      // random part, four idling phases, mode toggled between them
      for (int ph = 0; ph < 4; ph++) begin
         set_phase(phase_type'(ph));
         write_mode(ph[0]);
         if (ph == 0) hold_off <= 300;   // long receiver hold-off, pipe fills up
         for (int n = 0; n < 210; n++) begin
            send_triangle(random_triangle(), 1'b0, none);
            // occasional pause until everything is back
            if (n == 100) begin
               req_valid <= 1'b0;
               while (frames_due.size() != 0) @(posedge clock);
            end
         end
         drain_frames();
      end

      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
